### rtl/cpu_process_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// cpu process scheduler assertion macros
// shared property forms for the scheduler modules
// ----------------------------------------------------------------------------
`ifndef CPU_PROCESS_SCHEDULER_CORE_MACROS_SVH
`define CPU_PROCESS_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define CPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication
`define CPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

### rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// shared types, codes and constants of the cpu process scheduler
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int MAX_PROCS_DEF = 16;

    localparam logic [2:0] MODE_FCFS = 3'd0;
    localparam logic [2:0] MODE_SJF  = 3'd1;
    localparam logic [2:0] MODE_SRTF = 3'd2;
    localparam logic [2:0] MODE_RR   = 3'd3;
    localparam logic [2:0] MODE_PRIO = 3'd4;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_RAN  = 2'd1;
    localparam logic [1:0] KIND_IDLE = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_SLICE = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    localparam logic [23:0] TIME_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] remain;
        logic [23:0] arrival;
    } proc_rec_t;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic scan_step;
        logic decide;
        logic fin1;
        logic fin2;
        logic push;
    } cps_cmd_t;

    typedef struct packed {
        logic scan_done;
    } cps_status_t;

endpackage

### rtl/cpu_process_scheduler_core.sv
// ----------------------------------------------------------------------------
// cpu_process_scheduler_core
// process table scheduler with fcfs, sjf, srtf, round robin and priority modes
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  func slot proc_id prio burst arrival
// out      output     out_valid/out_stall kind run_id start_time end_time
//                                         left_time finished turnaround waiting
// cfg      input      apb write/read     mode time_slice entry_count
//
// load: capture, table write, then the result register; dispatch: capture, a
// table scan of one active entry per cycle, decide, fin1, fin2, result register
// one transaction in flight; the next is taken once the result is registered
// reset clears valid bits, time, scan pointer, scan and config registers at once
// a stalled result holds in the output register until taken
// ----------------------------------------------------------------------------
module cpu_process_scheduler_core #(
    parameter int MAX_PROCS = cps_pkg::MAX_PROCS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [3:0]  slot,
    input  logic [15:0] proc_id,
    input  logic [7:0]  prio,
    input  logic [15:0] burst,
    input  logic [23:0] arrival,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] run_id,
    output logic [23:0] start_time,
    output logic [23:0] end_time,
    output logic [15:0] left_time,
    output logic        finished,
    output logic [23:0] turnaround,
    output logic [23:0] waiting
);
    import cps_pkg::*;

    logic [2:0]  mode_reg;
    logic [15:0] slice_reg;
    logic [4:0]  count_reg;
    logic        cfg_wr;
    cps_cmd_t    cmd;
    cps_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FCFS;
            slice_reg <= 16'd1;
            count_reg <= 5'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MODE:  mode_reg  <= pwdata[2:0];
                REG_SLICE: slice_reg <= pwdata[15:0];
                REG_COUNT: count_reg <= pwdata[4:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:  prdata = {29'd0, mode_reg};
            REG_SLICE: prdata = {16'd0, slice_reg};
            REG_COUNT: prdata = {27'd0, count_reg};
            default:   prdata = '0;
        endcase
    end

    cps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cps_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_mode   (mode_reg),
        .cfg_slice  (slice_reg),
        .cfg_count  (count_reg),
        .slot       (slot),
        .proc_id    (proc_id),
        .prio       (prio),
        .burst      (burst),
        .arrival    (arrival),
        .kind       (kind),
        .run_id     (run_id),
        .start_time (start_time),
        .end_time   (end_time),
        .left_time  (left_time),
        .finished   (finished),
        .turnaround (turnaround),
        .waiting    (waiting)
    );

endmodule

### rtl/cps_ctrl.sv
// ----------------------------------------------------------------------------
// cps_ctrl
// sequencer for load and dispatch transactions and the result handshake
// ----------------------------------------------------------------------------
`include "cpu_process_scheduler_core_macros.svh"

module cps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  cps_pkg::cps_status_t status,
    output cps_pkg::cps_cmd_t    cmd
);
    import cps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_FIN1,
        ST_FIN2,
        ST_PUSH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   push;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign push      = (state_reg == ST_PUSH) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.capture   = accept;
        cmd.load_wr   = (state_reg == ST_LOAD);
        cmd.scan_step = (state_reg == ST_SCAN);
        cmd.decide    = (state_reg == ST_DECIDE);
        cmd.fin1      = (state_reg == ST_FIN1);
        cmd.fin2      = (state_reg == ST_FIN2);
        cmd.push      = push;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = push ? 1'b1 : (out_valid_reg && out_stall);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = func ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_PUSH;
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = ST_FIN1;
            ST_FIN1:   state_next = ST_FIN2;
            ST_FIN2:   state_next = ST_PUSH;
            ST_PUSH:
            begin
                if (push)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CPS_ASSERT_NEXT(a_accept_stalls, accept, in_stall)
    `CPS_ASSERT_NEXT(a_push_valid, push, out_valid)

endmodule

### rtl/cps_dp.sv
// ----------------------------------------------------------------------------
// cps_dp
// process table, selection scan, time keeping and result registers
// ----------------------------------------------------------------------------
`include "cpu_process_scheduler_core_macros.svh"

module cps_dp #(
    parameter int MAX_PROCS = cps_pkg::MAX_PROCS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cps_pkg::cps_cmd_t    cmd,
    output cps_pkg::cps_status_t status,
    input  logic [2:0]           cfg_mode,
    input  logic [15:0]          cfg_slice,
    input  logic [4:0]           cfg_count,
    input  logic [3:0]           slot,
    input  logic [15:0]          proc_id,
    input  logic [7:0]           prio,
    input  logic [15:0]          burst,
    input  logic [23:0]          arrival,
    output logic [1:0]           kind,
    output logic [15:0]          run_id,
    output logic [23:0]          start_time,
    output logic [23:0]          end_time,
    output logic [15:0]          left_time,
    output logic                 finished,
    output logic [23:0]          turnaround,
    output logic [23:0]          waiting
);
    import cps_pkg::*;

    localparam int AW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);

    proc_rec_t              mem_array [MAX_PROCS];
    logic [MAX_PROCS-1:0]   vld_reg;

    proc_rec_t   in_reg;
    logic [3:0]  slot_reg;

    logic [23:0]   now_reg;
    logic [AW-1:0] sp_reg;

    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] k_reg;
    logic          dv_reg;
    proc_rec_t     rd_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;

    proc_rec_t     best_reg;
    logic [AW-1:0] best_idx_reg;
    logic          found_reg;
    logic          pending_reg;

    logic [1:0]  kind_s_reg;
    logic [15:0] id_s_reg;
    logic [23:0] start_s_reg;
    logic [23:0] end_s_reg;
    logic [15:0] left_s_reg;
    logic        fin_s_reg;
    logic [23:0] ta_s_reg;
    logic [23:0] wait_s_reg;

    logic [1:0]  kind_reg;
    logic [15:0] run_id_reg;
    logic [23:0] start_reg;
    logic [23:0] end_reg;
    logic [15:0] left_reg;
    logic        fin_reg;
    logic [23:0] ta_reg;
    logic [23:0] wait_reg;

    logic [CW-1:0] n_act;
    logic [2:0]    m_eff;
    logic [15:0]   q_eff;
    logic [AW-1:0] scan_start;
    logic          issue;
    logic [AW-1:0] k_adv;
    logic [15:0]   ev_remain;
    logic          ev_ready;
    logic          better;
    logic          take;
    logic [15:0]   run;
    logic [24:0]   sum;
    logic [23:0]   new_now;
    logic [15:0]   remain_new;
    logic          slot_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    proc_rec_t     wr_data;
    logic [AW-1:0] sp_adv;

    always_comb
    begin
        if (32'(cfg_count) > MAX_PROCS)
        begin
            n_act = CW'(MAX_PROCS);
        end
        else
        begin
            n_act = CW'(cfg_count);
        end
        m_eff      = (cfg_mode > MODE_PRIO) ? MODE_FCFS : cfg_mode;
        q_eff      = (cfg_slice == 16'd0) ? 16'd1 : cfg_slice;
        // only round robin resumes at the scan pointer, other modes scan from entry zero
        scan_start = ((m_eff == MODE_RR) && (32'(sp_reg) < 32'(n_act))) ? sp_reg : '0;
        issue      = (cnt_reg < n_act);
        k_adv      = (32'(k_reg) + 1 >= 32'(n_act)) ? '0 : k_reg + AW'(1);
        sp_adv     = (32'(best_idx_reg) + 1 >= 32'(n_act)) ? '0 : best_idx_reg + AW'(1);
    end

    always_comb
    begin
        ev_remain = rd_vld_reg ? rd_reg.remain : 16'd0;
        ev_ready  = (ev_remain != 16'd0) && (rd_reg.arrival <= now_reg);
        case (m_eff)
            MODE_SJF:  better = rd_reg.burst < best_reg.burst;
            MODE_SRTF: better = ev_remain < best_reg.remain;
            MODE_PRIO: better = rd_reg.prio < best_reg.prio;
            default:   better = 1'b0;
        endcase
        take = dv_reg && ev_ready && (!found_reg || better);
    end

    assign status.scan_done = !issue && !dv_reg;

    always_comb
    begin
        if (!found_reg)
        begin
            run = 16'd1;
        end
        else if (m_eff == MODE_SRTF)
        begin
            run = 16'd1;
        end
        else if (m_eff == MODE_RR)
        begin
            run = (best_reg.remain > q_eff) ? q_eff : best_reg.remain;
        end
        else
        begin
            run = best_reg.remain;
        end
        sum        = {1'b0, now_reg} + 25'(run);
        new_now    = sum[24] ? TIME_MAX : sum[23:0];
        remain_new = best_reg.remain - run;
    end

    always_comb
    begin
        slot_ok = (32'(slot_reg) < MAX_PROCS);
        wr_en   = (cmd.load_wr && slot_ok) || (cmd.decide && pending_reg && found_reg);
        if (cmd.load_wr)
        begin
            wr_addr = AW'(slot_reg);
            wr_data = in_reg;
        end
        else
        begin
            wr_addr        = best_idx_reg;
            wr_data        = best_reg;
            wr_data.remain = remain_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (cmd.scan_step && issue)
        begin
            rd_reg <= mem_array[k_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            now_reg     <= '0;
            sp_reg      <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            dv_reg      <= 1'b0;
            found_reg   <= 1'b0;
            pending_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_wr && slot_ok)
            begin
                vld_reg[AW'(slot_reg)] <= 1'b1;
            end
            if (cmd.capture)
            begin
                cnt_reg     <= '0;
                k_reg       <= scan_start;
                dv_reg      <= 1'b0;
                found_reg   <= 1'b0;
                pending_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                dv_reg <= issue;
                if (issue)
                begin
                    rd_vld_reg <= vld_reg[k_reg];
                    cnt_reg    <= cnt_reg + CW'(1);
                    k_reg      <= k_adv;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
                if (dv_reg && (ev_remain != 16'd0))
                begin
                    pending_reg <= 1'b1;
                end
            end
            if (cmd.decide && pending_reg)
            begin
                now_reg <= new_now;
                if (found_reg && (m_eff == MODE_RR))
                begin
                    sp_reg <= sp_adv;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg       <= slot;
            in_reg.id      <= proc_id;
            in_reg.prio    <= prio;
            in_reg.burst   <= burst;
            in_reg.remain  <= burst;
            in_reg.arrival <= arrival;
        end
        if (cmd.scan_step)
        begin
            if (issue)
            begin
                rd_idx_reg <= k_reg;
            end
            if (take)
            begin
                best_reg     <= rd_reg;
                best_idx_reg <= rd_idx_reg;
            end
        end
        if (cmd.load_wr)
        begin
            kind_s_reg  <= KIND_LOAD;
            id_s_reg    <= '0;
            start_s_reg <= '0;
            end_s_reg   <= '0;
            left_s_reg  <= '0;
            fin_s_reg   <= 1'b0;
            ta_s_reg    <= '0;
            wait_s_reg  <= '0;
        end
        if (cmd.decide)
        begin
            start_s_reg <= now_reg;
            if (!pending_reg)
            begin
                kind_s_reg <= KIND_DONE;
                id_s_reg   <= '0;
                end_s_reg  <= now_reg;
                left_s_reg <= '0;
                fin_s_reg  <= 1'b0;
            end
            else if (!found_reg)
            begin
                kind_s_reg <= KIND_IDLE;
                id_s_reg   <= '0;
                end_s_reg  <= new_now;
                left_s_reg <= '0;
                fin_s_reg  <= 1'b0;
            end
            else
            begin
                kind_s_reg <= KIND_RAN;
                id_s_reg   <= best_reg.id;
                end_s_reg  <= new_now;
                left_s_reg <= remain_new;
                fin_s_reg  <= (remain_new == 16'd0);
            end
        end
        if (cmd.fin1)
        begin
            ta_s_reg <= fin_s_reg ? (end_s_reg - best_reg.arrival) : '0;
        end
        if (cmd.fin2)
        begin
            wait_s_reg <= (fin_s_reg && (ta_s_reg > 24'(best_reg.burst)))
                        ? (ta_s_reg - 24'(best_reg.burst)) : '0;
        end
        if (cmd.push)
        begin
            kind_reg   <= kind_s_reg;
            run_id_reg <= id_s_reg;
            start_reg  <= start_s_reg;
            end_reg    <= end_s_reg;
            left_reg   <= left_s_reg;
            fin_reg    <= fin_s_reg;
            ta_reg     <= ta_s_reg;
            wait_reg   <= wait_s_reg;
        end
    end

    assign kind       = kind_reg;
    assign run_id     = run_id_reg;
    assign start_time = start_reg;
    assign end_time   = end_reg;
    assign left_time  = left_reg;
    assign finished   = fin_reg;
    assign turnaround = ta_reg;
    assign waiting    = wait_reg;

    `CPS_ASSERT_NOW(a_sel_in_range, cmd.decide && found_reg, 32'(best_idx_reg) < 32'(n_act))
    `CPS_ASSERT_NEXT(a_now_monotonic, 1'b1, now_reg >= $past(now_reg))

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu process scheduler core testbench
// loads process tables and asks for dispatches under every scheduling mode,
// predicts each load ack, run, idle tick and all-done report and compares
// them field by field, with random input gaps and random output stalls
// ----------------------------------------------------------------------------
module tb;
    import cps_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] run_id;
        logic [23:0] start_time;
        logic [23:0] end_time;
        logic [15:0] left_time;
        logic        finished;
        logic [23:0] turnaround;
        logic [23:0] waiting;
    } sched_rpt_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [3:0]  slot;
    logic [15:0] proc_id;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [23:0] arrival;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [15:0] run_id;
    logic [23:0] start_time;
    logic [23:0] end_time;
    logic [15:0] left_time;
    logic        finished;
    logic [23:0] turnaround;
    logic [23:0] waiting;

    cpu_process_scheduler_core uut (.*);

    // scheduler shadow state
    logic [15:0] p_id [16];
    logic [7:0]  p_prio [16];
    logic [15:0] p_burst [16];
    logic [15:0] p_remain [16];
    logic [23:0] p_arrival [16];
    logic [23:0] p_now;
    logic [4:0]  p_ptr;
    logic [2:0]  cur_mode;
    logic [15:0] cur_slice;
    logic [4:0]  cur_count;

    sched_rpt_t expected_reports[$];
    int errors;
    int reports_seen;
    int cycles;
    int stall_mode;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("cpu_process_scheduler_core: mismatch");
            $finish;
        end
    end

    function automatic sched_rpt_t schedule_item(logic f, logic [3:0] s, logic [15:0] id,
                                                 logic [7:0] pr, logic [15:0] b,
                                                 logic [23:0] a);
        sched_rpt_t r;
        int n, sel, run, st, ta, q;
        logic found, pending;
        logic [2:0] m;
        r = '0;
        n = (cur_count > 16) ? 16 : cur_count;
        sel = 0;
        found = 1'b0;
        pending = 1'b0;
        if (!f)
        begin
            p_id[s] = id;
            p_prio[s] = pr;
            p_burst[s] = b;
            p_remain[s] = b;
            p_arrival[s] = a;
            r.kind = KIND_LOAD;
            return r;
        end
        for (int i = 0; i < n; i++)
            if (p_remain[i] != 0) pending = 1'b1;
        if (!pending)
        begin
            r.kind = KIND_DONE;
            r.start_time = p_now;
            r.end_time = p_now;
            return r;
        end
        m = (cur_mode > MODE_PRIO) ? MODE_FCFS : cur_mode;
        if (m == MODE_RR)
        begin
            st = (p_ptr < n) ? p_ptr : 0;
            for (int i = 0; i < n && !found; i++)
            begin
                int k;
                k = (st + i >= n) ? st + i - n : st + i;
                if (p_remain[k] != 0 && p_arrival[k] <= p_now)
                begin
                    sel = k;
                    found = 1'b1;
                end
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                logic better;
                if (!(p_remain[i] != 0 && p_arrival[i] <= p_now)) continue;
                if (!found) better = 1'b1;
                else if (m == MODE_SJF) better = p_burst[i] < p_burst[sel];
                else if (m == MODE_SRTF) better = p_remain[i] < p_remain[sel];
                else if (m == MODE_PRIO) better = p_prio[i] < p_prio[sel];
                else better = 1'b0;
                if (better)
                begin
                    sel = i;
                    found = 1'b1;
                end
            end
        end
        if (!found)
        begin
            r.kind = KIND_IDLE;
            r.start_time = p_now;
            if (p_now != TIME_MAX) p_now = p_now + 24'd1;
            r.end_time = p_now;
            return r;
        end
        if (m == MODE_SRTF) run = 1;
        else if (m == MODE_RR)
        begin
            q = (cur_slice == 0) ? 1 : cur_slice;
            run = (p_remain[sel] > q) ? q : p_remain[sel];
            p_ptr = (sel + 1 >= n) ? 5'd0 : 5'(sel + 1);
        end
        else run = p_remain[sel];
        r.kind = KIND_RAN;
        r.run_id = p_id[sel];
        r.start_time = p_now;
        p_now = (int'(p_now) + run > int'(TIME_MAX)) ? TIME_MAX : 24'(int'(p_now) + run);
        r.end_time = p_now;
        p_remain[sel] = 16'(int'(p_remain[sel]) - run);
        r.left_time = p_remain[sel];
        if (p_remain[sel] == 0)
        begin
            ta = int'(p_now) - int'(p_arrival[sel]);
            r.finished = 1'b1;
            r.turnaround = 24'(ta);
            r.waiting = (ta > p_burst[sel]) ? 24'(ta - p_burst[sel]) : 24'd0;
        end
        return r;
    endfunction

    // result checker and stall generator
    always @(posedge clk)
    begin
        sched_rpt_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            reports_seen <= reports_seen + 1;
            if (expected_reports.size() == 0)
            begin
                $error("unexpected transaction kind=%0d", kind);
                errors <= errors + 1;
            end
            else
            begin
                exp_r = expected_reports.pop_front();
                if (kind != exp_r.kind)
                begin
                    $error("kind exp %0d got %0d", exp_r.kind, kind);
                    errors <= errors + 1;
                end
                if (run_id != exp_r.run_id)
                begin
                    $error("run_id exp %0d got %0d", exp_r.run_id, run_id);
                    errors <= errors + 1;
                end
                if (start_time != exp_r.start_time)
                begin
                    $error("start_time exp %0d got %0d", exp_r.start_time, start_time);
                    errors <= errors + 1;
                end
                if (end_time != exp_r.end_time)
                begin
                    $error("end_time exp %0d got %0d", exp_r.end_time, end_time);
                    errors <= errors + 1;
                end
                if (left_time != exp_r.left_time)
                begin
                    $error("left_time exp %0d got %0d", exp_r.left_time, left_time);
                    errors <= errors + 1;
                end
                if (finished != exp_r.finished)
                begin
                    $error("finished exp %0d got %0d", exp_r.finished, finished);
                    errors <= errors + 1;
                end
                if (turnaround != exp_r.turnaround)
                begin
                    $error("turnaround exp %0d got %0d", exp_r.turnaround, turnaround);
                    errors <= errors + 1;
                end
                if (waiting != exp_r.waiting)
                begin
                    $error("waiting exp %0d got %0d", exp_r.waiting, waiting);
                    errors <= errors + 1;
                end
            end
        end
        if (stall_mode == 0) out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 3) out_stall <= ($urandom_range(0, 3) == 0);
        else if ($urandom_range(0, 99) < 30) out_stall <= ~out_stall;
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:  cur_mode = val[2:0];
            REG_SLICE: cur_slice = val[15:0];
            default:   cur_count = val[4:0];
        endcase
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_regs(logic [2:0] m, logic [15:0] q, logic [4:0] n);
        drain();
        reg_write(REG_MODE, {29'd0, m});
        reg_write(REG_SLICE, {16'd0, q});
        reg_write(REG_COUNT, {27'd0, n});
    endtask

    task automatic send_item(logic f, logic [3:0] s, logic [15:0] id, logic [7:0] pr,
                             logic [15:0] b, logic [23:0] a);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        slot <= s;
        proc_id <= id;
        prio <= pr;
        burst <= b;
        arrival <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_reports.push_back(schedule_item(f, s, id, pr, b, a));
    endtask

    task automatic load_rand(int s, int bmax, int amax);
        send_item(1'b0, 4'(s), 16'($urandom), 8'($urandom), 16'($urandom_range(0, bmax)),
                  24'(int'(p_now) + $urandom_range(0, amax)));
    endtask

    task automatic test_directed;
        set_regs(MODE_FCFS, 1, 4);
        send_item(1'b1, 0, 0, 0, 0, 0);
        send_item(1'b0, 0, 16'hFFFF, 8'hFF, 16'hFFFF, 0);
        send_item(1'b0, 15, 16'h0000, 8'h00, 16'h0001, 24'hFFFFFF);
        send_item(1'b0, 1, 16'h1234, 8'h00, 0, 0);
        send_item(1'b0, 2, 16'hABCD, 8'h01, 3, 50);
        send_item(1'b1, 0, 0, 0, 0, 0);
        send_item(1'b1, 0, 0, 0, 0, 0);
        send_item(1'b1, 0, 0, 0, 0, 0);
        set_regs(3'd7, 0, 0);
        send_item(1'b1, 0, 0, 0, 0, 0);
        set_regs(MODE_RR, 0, 16);
        send_item(1'b1, 0, 0, 0, 0, 0);
        send_item(1'b0, 3, 16'h5555, 8'hAA, 16'hFFFF, 24'hFFFFFF);
        send_item(1'b0, 4, 16'hAAAA, 8'h55, 5, 0);
        send_item(1'b1, 0, 0, 0, 0, 0);
        send_item(1'b1, 0, 0, 0, 0, 0);
        set_regs(MODE_SRTF, 16'hFFFF, 31);
        send_item(1'b1, 0, 0, 0, 0, 0);
        send_item(1'b1, 0, 0, 0, 0, 0);
    endtask

    // long runs push time into saturation, so this goes last
    task automatic test_saturation;
        set_regs(MODE_FCFS, 1, 16);
        for (int i = 0; i < 300; i++)
        begin
            send_item(1'b0, 4'(i), 16'(i), 8'd0, 16'hFFFF, 24'd0);
            send_item(1'b1, 4'd0, 16'd0, 8'd0, 16'd0, 24'd0);
        end
        set_regs(MODE_FCFS, 1, 16);
        for (int i = 0; i < 16; i++)
            send_item(1'b0, 4'(i), 16'(i), 8'd0, 16'd0, 24'd0);
        send_item(1'b1, 4'd0, 16'd0, 8'd0, 16'd0, 24'd0);
    endtask

    task automatic test_mode(logic [2:0] m, int items);
        int n;
        n = $urandom_range(1, 16);
        if ($urandom_range(0, 3) == 0) n = 16;
        set_regs(m, ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                 ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31)) : 5'(n));
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(0, 9) < 3)
                load_rand($urandom_range(0, 15),
                          ($urandom_range(0, 9) == 0) ? 65535 : 12,
                          ($urandom_range(0, 9) == 0) ? 200 : 8);
            else
                send_item(1'b1, 4'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                          24'($urandom));
            if (i == items / 2 && m == MODE_RR) drain();
        end
    endtask

    initial
    begin
        int rounds;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        func = 1'b0;
        slot = '0;
        proc_id = '0;
        prio = '0;
        burst = '0;
        arrival = '0;
        out_stall = 1'b0;
        errors = 0;
        reports_seen = 0;
        cycles = 0;
        stall_mode = 0;
        p_now = '0;
        p_ptr = '0;
        cur_mode = MODE_FCFS;
        cur_slice = 1;
        cur_count = 1;
        for (int i = 0; i < 16; i++)
        begin
            p_remain[i] = '0;
            p_id[i] = '0;
            p_prio[i] = '0;
            p_burst[i] = '0;
            p_arrival[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        rounds = 0;
        while (rounds < 14)
        begin
            stall_mode = rounds % 3;
            test_mode(3'(rounds % 8), 47);
            rounds++;
        end
        stall_mode = 1;
        test_saturation();
        drain();
        $display("covered all five modes plus unused codes, slice and count extremes,");
        $display("time saturation and idle ticks; %0d transactions checked", reports_seen);
        if (errors == 0 && expected_reports.size() == 0)
            $display("cpu_process_scheduler_core: match");
        else
            $display("cpu_process_scheduler_core: mismatch");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/cps_pkg.sv
rtl/cps_ctrl.sv
rtl/cps_dp.sv
rtl/cpu_process_scheduler_core.sv
tb/tb.sv
